// ----- rtl/core/windowed_request_pacer_with_aimd_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the request pacer
// Shared concurrent assertion forms, clocked and gated by reset.
// ---------------------------------------------------------------------------
`ifndef WINDOWED_REQUEST_PACER_WITH_AIMD_TOP_MACROS_SVH
`define WINDOWED_REQUEST_PACER_WITH_AIMD_TOP_MACROS_SVH

// Same-cycle implication
`define WRPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pacer assertion failed");

// Next-cycle implication
`define WRPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pacer assertion failed");

`endif

// ----- rtl/core/wrpa_pkg.sv -----
// ---------------------------------------------------------------------------
// wrpa_pkg
// Types, register map and constants of the windowed request pacer.
// ---------------------------------------------------------------------------
package wrpa_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_SEND    = 2'd1,
        CMD_DATA    = 2'd2,
        CMD_TIMEOUT = 2'd3
    } cmd_t;

    // Register indexes (word address)
    typedef enum logic [1:0] {
        REG_WINDOW_INTERVAL  = 2'd0,
        REG_INITIAL_WINDOW   = 2'd1,
        REG_INITIAL_LIFETIME = 2'd2
    } reg_idx_t;

    localparam int unsigned PADDR_W = 4;

    localparam logic [15:0] WINDOW_INTERVAL_RST  = 16'd100;
    localparam logic [7:0]  INITIAL_WINDOW_RST   = 8'd5;
    localparam logic [15:0] INITIAL_LIFETIME_RST = 16'd4000;

    localparam logic [3:0]  SAMPLES_PER_BATCH = 4'd10;
    localparam logic [2:0]  CREDIT_PER_SLOT   = 3'd5;
    localparam logic [7:0]  WINDOW_MAX        = 8'd255;
    localparam logic [15:0] LIFETIME_MAX      = 16'd65535;
    localparam logic [31:0] ELAPSED_MAX       = 32'hFFFF_FFFF;

    // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT, exact for x below 2^22
    localparam logic [19:0] DIV10_MUL   = 20'd838861;
    localparam int unsigned DIV10_SHIFT = 23;
    // 3 * sum at or above this gives a lifetime beyond 16 bits
    localparam logic [21:0] LIFETIME_SAT_AT = 22'd655360;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] request_due_ms;
        logic [15:0] rtt_ms;
    } in_item_t;

    typedef struct packed {
        logic        grant;
        logic [7:0]  window_now;
        logic [7:0]  sent_in_interval;
        logic [15:0] lifetime_ms;
        logic [19:0] avg_rtt_tenths;
    } out_item_t;

    typedef struct packed {
        logic [15:0] window_interval_ms;
        logic [7:0]  initial_window;
        logic [15:0] initial_lifetime_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] elapsed_ms;
        logic [15:0] interval_timer;
        logic [7:0]  sent_count;
        logic [7:0]  window_size;
        logic [2:0]  growth_credit;
        logic [3:0]  sample_count;
        logic [19:0] running_sum;
        logic [19:0] batch_sum;
        logic [15:0] lifetime;
    } state_t;

    // A zero window load is taken as one
    function automatic logic [7:0] load_window(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

// ----- rtl/core/wrpa_step.sv -----
// ---------------------------------------------------------------------------
// wrpa_step
// Next-state function of the pacer for one item: interval timing, grant
// decision, batch averaging and window adjustment.
// ---------------------------------------------------------------------------
module wrpa_step
    import wrpa_pkg::*;
(
    input  cfg_t     cfg,
    input  state_t   state,
    input  in_item_t item,
    output state_t   state_next,
    output logic     grant
);

    logic [15:0] timer_inc;
    logic [3:0]  count_inc;
    logic        batch_end;
    logic [19:0] sum_inc;
    logic [19:0] batch_new;
    logic [21:0] triple_sum;
    logic [39:0] div_prod;
    logic [15:0] lifetime_new;
    logic [23:0] rtt_x100;
    logic [23:0] sum_x11;
    logic [22:0] rtt_x20;
    logic [22:0] sum_x3;
    logic        fast;
    logic        slow;
    logic [2:0]  credit_inc;
    logic [7:0]  window_half;

    // Interval timer advance
    assign timer_inc = state.interval_timer + 16'd1;

    // Batch accumulation
    assign count_inc = state.sample_count + 4'd1;
    assign batch_end = (count_inc >= SAMPLES_PER_BATCH);
    assign sum_inc   = state.running_sum + {4'd0, item.rtt_ms};
    assign batch_new = batch_end ? sum_inc : state.batch_sum;

    // Lifetime = floor(3 * sum / 10), saturated
    assign triple_sum   = {2'd0, sum_inc} + {1'b0, sum_inc, 1'b0};
    assign div_prod     = triple_sum[19:0] * DIV10_MUL;
    assign lifetime_new = (triple_sum >= LIFETIME_SAT_AT) ? LIFETIME_MAX
                                                           : div_prod[38:DIV10_SHIFT];

    // Compare sample against average: fast below 1.1x, slow above 1.5x
    assign rtt_x100 = 24'(item.rtt_ms) * 24'd100;
    assign sum_x11  = 24'(batch_new) * 24'd11;
    assign rtt_x20  = 23'(item.rtt_ms) * 23'd20;
    assign sum_x3   = 23'(batch_new) * 23'd3;
    assign fast     = (rtt_x100 < sum_x11);
    assign slow     = (rtt_x20 > sum_x3);

    assign credit_inc  = state.growth_credit + 3'd1;
    assign window_half = 8'(({1'b0, state.window_size} + 9'd1) >> 1);

    // Apply the item
    always_comb begin
        state_next = state;
        grant      = 1'b0;
        unique case (item.cmd)
            CMD_TICK: begin
                if (state.elapsed_ms != ELAPSED_MAX) begin
                    state_next.elapsed_ms = state.elapsed_ms + 32'd1;
                end
                if (timer_inc >= cfg.window_interval_ms) begin
                    state_next.interval_timer = 16'd0;
                    state_next.sent_count     = 8'd0;
                end else begin
                    state_next.interval_timer = timer_inc;
                end
            end
            CMD_SEND: begin
                if (item.request_due_ms <= state.elapsed_ms &&
                    state.sent_count < state.window_size) begin
                    grant                 = 1'b1;
                    state_next.sent_count = state.sent_count + 8'd1;
                end
            end
            CMD_DATA: begin
                if (batch_end) begin
                    state_next.batch_sum    = sum_inc;
                    state_next.running_sum  = 20'd0;
                    state_next.sample_count = 4'd0;
                    state_next.lifetime     = lifetime_new;
                end else begin
                    state_next.running_sum  = sum_inc;
                    state_next.sample_count = count_inc;
                end
                if (batch_new != 20'd0) begin
                    if (fast) begin
                        if (credit_inc >= CREDIT_PER_SLOT) begin
                            state_next.growth_credit = 3'd0;
                            if (state.window_size < WINDOW_MAX) begin
                                state_next.window_size = state.window_size + 8'd1;
                            end
                        end else begin
                            state_next.growth_credit = credit_inc;
                        end
                    end else if (slow && state.window_size > 8'd2) begin
                        state_next.window_size = state.window_size - 8'd2;
                    end
                end
            end
            CMD_TIMEOUT: begin
                if (state.window_size > 8'd1) begin
                    state_next.window_size = window_half;
                end
            end
            default: begin
                state_next = state;
            end
        endcase
    end

endmodule

// ----- rtl/core/windowed_request_pacer_with_aimd_top.sv -----
// ---------------------------------------------------------------------------
// windowed_request_pacer_with_aimd_top
// Request pacer with an additive-increase, multiplicative-decrease window.
// ---------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry items: a 1 ms tick, a send request with its
//   due time, a data arrival with its round-trip time, or a timeout.
//   m_valid/m_ready/m_data return one result per item: the grant decision and
//   the window, sent count, lifetime and batch average after the update.
//   The APB port holds the interval length, the initial window and the
//   initial lifetime; writing either initial value loads it at once.
// Timing:
//   An item transfers when s_valid and s_ready are both high; its result is valid in the next cycle.
//   One item per cycle is sustained while m_ready is high: the whole state update is
//   one pass of compare, add and multiply logic between the state and result registers.
// Reset:
//   aresetn (synchronous) restores the register defaults, clears all
//   counters and sums, and empties the result register.
// Backpressure:
//   When m_ready is low with a result held, s_ready drops until the result
//   transfers; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "windowed_request_pacer_with_aimd_top_macros.svh"

module windowed_request_pacer_with_aimd_top
    import wrpa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    cfg_t      cfg_reg;
    state_t    state_reg;
    state_t    state_next;
    logic      grant_next;
    logic      m_valid_reg;
    out_item_t m_data_reg;
    logic      s_xfer;
    logic      cfg_wr;
    reg_idx_t  reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Register readback
    always_comb begin
        unique case (reg_idx)
            REG_WINDOW_INTERVAL:  prdata = {16'd0, cfg_reg.window_interval_ms};
            REG_INITIAL_WINDOW:   prdata = {24'd0, cfg_reg.initial_window};
            REG_INITIAL_LIFETIME: prdata = {16'd0, cfg_reg.initial_lifetime_ms};
            default:              prdata = 32'd0;
        endcase
    end

    // Per-item update
    wrpa_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (s_data),
        .state_next (state_next),
        .grant      (grant_next)
    );

    // Configuration and pacer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_interval_ms  <= WINDOW_INTERVAL_RST;
            cfg_reg.initial_window      <= INITIAL_WINDOW_RST;
            cfg_reg.initial_lifetime_ms <= INITIAL_LIFETIME_RST;
            state_reg.elapsed_ms        <= 32'd0;
            state_reg.interval_timer    <= 16'd0;
            state_reg.sent_count        <= 8'd0;
            state_reg.window_size       <= load_window(INITIAL_WINDOW_RST);
            state_reg.growth_credit     <= 3'd0;
            state_reg.sample_count      <= 4'd0;
            state_reg.running_sum       <= 20'd0;
            state_reg.batch_sum         <= 20'd0;
            state_reg.lifetime          <= INITIAL_LIFETIME_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WINDOW_INTERVAL: begin
                    cfg_reg.window_interval_ms <= pwdata[15:0];
                end
                REG_INITIAL_WINDOW: begin
                    cfg_reg.initial_window <= pwdata[7:0];
                    state_reg.window_size  <= load_window(pwdata[7:0]);
                end
                REG_INITIAL_LIFETIME: begin
                    cfg_reg.initial_lifetime_ms <= pwdata[15:0];
                    state_reg.lifetime          <= pwdata[15:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end else if (s_xfer) begin
            state_reg <= state_next;
        end
    end

    // Result valid: load on transfer in, clear on transfer out
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_data_reg.grant            <= grant_next;
            m_data_reg.window_now       <= state_next.window_size;
            m_data_reg.sent_in_interval <= state_next.sent_count;
            m_data_reg.lifetime_ms      <= state_next.lifetime;
            m_data_reg.avg_rtt_tenths   <= state_next.batch_sum;
        end
    end

    // Checks
    `WRPA_ASSERT_IMP(a_window_nonzero, aclk, aresetn, 1'b1, state_reg.window_size != 8'd0)
    `WRPA_ASSERT_IMP(a_batch_count, aclk, aresetn, 1'b1, state_reg.sample_count < SAMPLES_PER_BATCH)
    `WRPA_ASSERT_IMP(a_credit_range, aclk, aresetn, 1'b1, state_reg.growth_credit < CREDIT_PER_SLOT)
    `WRPA_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_xfer, m_valid)
    `WRPA_ASSERT_IMP(a_grant_counted, aclk, aresetn, m_valid && m_data.grant, m_data.sent_in_interval != 8'd0)

endmodule
